>>> design/ccd_pkg.sv
`default_nettype none

package ccd_pkg;

    localparam int KINDS     = 5;
    localparam int MAX_COINS = 255;
    localparam int STOCK_W   = 8;
    localparam int GIVE_W    = 8;
    localparam int CENTS_W   = 16;
    localparam int KIND_W    = 3;
    localparam int OP_W      = 2;
    localparam int VALUE_W   = 7;
    localparam int RECIP_W   = 17;
    localparam int SHIFT_W   = 5;
    localparam int TAKE_P_W  = STOCK_W + VALUE_W;
    localparam int RECIP_P_W = CENTS_W + RECIP_W;

    localparam logic [OP_W-1:0] OP_SUPPLY = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_CHANGE = 2'd2;

    localparam logic [KIND_W-1:0] KIND_FIVE    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TEN     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_QUARTER = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HALF    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UNIT    = 3'd4;

    typedef enum logic [2:0] {
        ST_OK,
        ST_UNDERPAID,
        ST_EXACT,
        ST_NOCHANGE,
        ST_FULL,
        ST_EMPTY
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;
        logic              prep;
        logic              divide;
        logic              take;
        logic              publish;
        logic [KIND_W-1:0] kind;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_greedy;
        logic out_free;
    } stat_t;

    function automatic logic [VALUE_W-1:0] coin_value(input logic [KIND_W-1:0] k);
        logic [VALUE_W-1:0] v;
        unique case (k)
            KIND_FIVE:    v = 7'd5;
            KIND_TEN:     v = 7'd10;
            KIND_QUARTER: v = 7'd25;
            KIND_HALF:    v = 7'd50;
            KIND_UNIT:    v = 7'd100;
            default:      v = 7'd0;
        endcase
        return v;
    endfunction

    // Reciprocal multipliers that give an exact quotient for any 16-bit dividend.
    function automatic logic [RECIP_W-1:0] coin_recip(input logic [KIND_W-1:0] k);
        logic [RECIP_W-1:0] m;
        unique case (k)
            KIND_FIVE:    m = 17'd104858;
            KIND_TEN:     m = 17'd104858;
            KIND_QUARTER: m = 17'd83887;
            KIND_HALF:    m = 17'd83887;
            KIND_UNIT:    m = 17'd83887;
            default:      m = 17'd0;
        endcase
        return m;
    endfunction

    function automatic logic [SHIFT_W-1:0] coin_shift(input logic [KIND_W-1:0] k);
        logic [SHIFT_W-1:0] s;
        unique case (k)
            KIND_FIVE:    s = 5'd19;
            KIND_TEN:     s = 5'd20;
            KIND_QUARTER: s = 5'd21;
            KIND_HALF:    s = 5'd22;
            KIND_UNIT:    s = 5'd23;
            default:      s = 5'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> design/coin_change_dispenser_unit.sv
// A supply, remove or rejected change item passes PREP and FINISH, its result published
// once the output is free; a change that runs the greedy walk passes DIV then TAKE per
// denomination. Items go one at a time, taken only in IDLE; the shared reciprocal divider
// serves the five denominations in turn; the next item is taken while a result waits.
// Reset: synchronous, active low; clears all coin counts and drops the output valid.
`default_nettype none

module coin_change_dispenser_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [ccd_pkg::OP_W-1:0]      s_operation,
    input  wire logic [ccd_pkg::KIND_W-1:0]    s_coin_kind,
    input  wire logic [ccd_pkg::CENTS_W-1:0]   s_paid_cents,
    input  wire logic [ccd_pkg::CENTS_W-1:0]   s_price_cents,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [2:0]                         m_status,
    output logic [ccd_pkg::GIVE_W-1:0]         m_give_five,
    output logic [ccd_pkg::GIVE_W-1:0]         m_give_ten,
    output logic [ccd_pkg::GIVE_W-1:0]         m_give_quarter,
    output logic [ccd_pkg::GIVE_W-1:0]         m_give_half,
    output logic [ccd_pkg::GIVE_W-1:0]         m_give_unit
);

    ccd_pkg::cmd_t  cmd;
    ccd_pkg::stat_t stat;

    ccd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ccd_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_operation    (s_operation),
        .s_coin_kind    (s_coin_kind),
        .s_paid_cents   (s_paid_cents),
        .s_price_cents  (s_price_cents),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_status       (m_status),
        .m_give_five    (m_give_five),
        .m_give_ten     (m_give_ten),
        .m_give_quarter (m_give_quarter),
        .m_give_half    (m_give_half),
        .m_give_unit    (m_give_unit)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again right after an item was accepted");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= 3'(ccd_pkg::ST_EMPTY))
        else $error("result status out of range");

    a_give_only_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != 3'(ccd_pkg::ST_OK) |->
            m_give_five == '0 && m_give_ten == '0 && m_give_quarter == '0 &&
            m_give_half == '0 && m_give_unit == '0)
        else $error("coins dispensed on a failed item");

endmodule

`default_nettype wire

>>> design/ccd_ctrl.sv
`default_nettype none

module ccd_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire ccd_pkg::stat_t stat,
    output ccd_pkg::cmd_t       cmd
);

    typedef enum logic [2:0] {
        IDLE,
        PREP,
        DIV,
        TAKE,
        FINISH
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [ccd_pkg::KIND_W-1:0] kind_reg;
    logic [ccd_pkg::KIND_W-1:0] kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            kind_reg  <= ccd_pkg::KIND_UNIT;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        unique case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    state_next = PREP;
                end
            end
            PREP: begin
                kind_next = ccd_pkg::KIND_UNIT;
                if (stat.need_greedy) begin
                    state_next = DIV;
                end else begin
                    state_next = FINISH;
                end
            end
            DIV: begin
                state_next = TAKE;
            end
            TAKE: begin
                if (kind_reg == ccd_pkg::KIND_FIVE) begin
                    state_next = FINISH;
                end else begin
                    kind_next  = kind_reg - 3'd1;
                    state_next = DIV;
                end
            end
            FINISH: begin
                if (stat.out_free) begin
                    state_next = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    assign s_ready     = (state_reg == IDLE);
    assign cmd.load    = s_valid && (state_reg == IDLE);
    assign cmd.prep    = (state_reg == PREP);
    assign cmd.divide  = (state_reg == DIV);
    assign cmd.take    = (state_reg == TAKE);
    assign cmd.publish = (state_reg == FINISH) && stat.out_free;
    assign cmd.kind    = kind_reg;

endmodule

`default_nettype wire

>>> design/ccd_datapath.sv
`default_nettype none

module ccd_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire ccd_pkg::cmd_t                 cmd,
    output ccd_pkg::stat_t                     stat,
    input  wire logic [ccd_pkg::OP_W-1:0]      s_operation,
    input  wire logic [ccd_pkg::KIND_W-1:0]    s_coin_kind,
    input  wire logic [ccd_pkg::CENTS_W-1:0]   s_paid_cents,
    input  wire logic [ccd_pkg::CENTS_W-1:0]   s_price_cents,
    input  wire logic                          m_ready,
    output logic                               m_valid,
    output logic [2:0]                         m_status,
    output logic [ccd_pkg::GIVE_W-1:0]         m_give_five,
    output logic [ccd_pkg::GIVE_W-1:0]         m_give_ten,
    output logic [ccd_pkg::GIVE_W-1:0]         m_give_quarter,
    output logic [ccd_pkg::GIVE_W-1:0]         m_give_half,
    output logic [ccd_pkg::GIVE_W-1:0]         m_give_unit
);

    logic [ccd_pkg::OP_W-1:0]      op_reg;
    logic [ccd_pkg::KIND_W-1:0]    kind_reg;
    logic [ccd_pkg::CENTS_W-1:0]   paid_reg;
    logic [ccd_pkg::CENTS_W-1:0]   price_reg;
    logic [ccd_pkg::CENTS_W-1:0]   left_reg;
    logic [ccd_pkg::CENTS_W-1:0]   quot_reg;
    logic [ccd_pkg::GIVE_W-1:0]    give_reg [ccd_pkg::KINDS];
    ccd_pkg::status_t              status_reg;
    logic [ccd_pkg::STOCK_W-1:0]   stock_reg [ccd_pkg::KINDS];
    logic                          m_valid_reg;
    ccd_pkg::status_t              m_status_reg;
    logic [ccd_pkg::GIVE_W-1:0]    m_give_reg [ccd_pkg::KINDS];

    logic                          kind_known;
    logic [ccd_pkg::STOCK_W-1:0]   slot_stock;
    logic [ccd_pkg::STOCK_W-1:0]   greedy_stock;
    logic [ccd_pkg::RECIP_P_W-1:0] recip_prod;
    logic [ccd_pkg::STOCK_W-1:0]   take_val;
    logic [ccd_pkg::TAKE_P_W-1:0]  take_prod;
    logic [ccd_pkg::CENTS_W-1:0]   left_rem;
    logic                          five_ok;

    assign kind_known   = (kind_reg <= ccd_pkg::KIND_UNIT);
    assign slot_stock   = kind_known ? stock_reg[kind_reg] : '0;
    assign greedy_stock = stock_reg[cmd.kind];

    // The quotient caps at the stock, so the product never exceeds what is left.
    assign recip_prod = left_reg * ccd_pkg::coin_recip(cmd.kind);
    assign take_val   = (quot_reg > ccd_pkg::CENTS_W'(greedy_stock)) ?
                        greedy_stock : quot_reg[ccd_pkg::STOCK_W-1:0];
    assign take_prod  = take_val * ccd_pkg::coin_value(cmd.kind);
    assign left_rem   = left_reg - ccd_pkg::CENTS_W'(take_prod);
    assign five_ok    = (quot_reg <= ccd_pkg::CENTS_W'(greedy_stock)) && (left_rem == '0);

    assign stat.need_greedy = (op_reg == ccd_pkg::OP_CHANGE) && (paid_reg > price_reg);
    assign stat.out_free    = !m_valid_reg || m_ready;

    // Coin stock and the output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < ccd_pkg::KINDS; j++) begin
                stock_reg[j] <= '0;
            end
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.prep && kind_known) begin
                if (op_reg == ccd_pkg::OP_SUPPLY &&
                    slot_stock < ccd_pkg::STOCK_W'(ccd_pkg::MAX_COINS)) begin
                    stock_reg[kind_reg] <= slot_stock + 8'd1;
                end else if (op_reg == ccd_pkg::OP_REMOVE && slot_stock != '0) begin
                    stock_reg[kind_reg] <= slot_stock - 8'd1;
                end
            end
            if (cmd.take && cmd.kind == ccd_pkg::KIND_FIVE && five_ok) begin
                stock_reg[ccd_pkg::KIND_FIVE] <= stock_reg[ccd_pkg::KIND_FIVE] - take_val;
                for (int j = 1; j < ccd_pkg::KINDS; j++) begin
                    stock_reg[j] <= stock_reg[j] - give_reg[j];
                end
            end
            if (cmd.publish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Item registers, the greedy walk and the result register.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_operation;
            kind_reg  <= s_coin_kind;
            paid_reg  <= s_paid_cents;
            price_reg <= s_price_cents;
        end
        if (cmd.prep) begin
            for (int j = 0; j < ccd_pkg::KINDS; j++) begin
                give_reg[j] <= '0;
            end
            left_reg <= paid_reg - price_reg;
            case (op_reg)
                ccd_pkg::OP_SUPPLY: begin
                    if (kind_known &&
                        slot_stock >= ccd_pkg::STOCK_W'(ccd_pkg::MAX_COINS)) begin
                        status_reg <= ccd_pkg::ST_FULL;
                    end else begin
                        status_reg <= ccd_pkg::ST_OK;
                    end
                end
                ccd_pkg::OP_REMOVE: begin
                    if (kind_known && slot_stock == '0) begin
                        status_reg <= ccd_pkg::ST_EMPTY;
                    end else begin
                        status_reg <= ccd_pkg::ST_OK;
                    end
                end
                ccd_pkg::OP_CHANGE: begin
                    if (paid_reg < price_reg) begin
                        status_reg <= ccd_pkg::ST_UNDERPAID;
                    end else if (paid_reg == price_reg) begin
                        status_reg <= ccd_pkg::ST_EXACT;
                    end else begin
                        status_reg <= ccd_pkg::ST_OK;
                    end
                end
                default: begin
                    status_reg <= ccd_pkg::ST_OK;
                end
            endcase
        end
        if (cmd.divide) begin
            quot_reg <= ccd_pkg::CENTS_W'(recip_prod >> ccd_pkg::coin_shift(cmd.kind));
        end
        if (cmd.take) begin
            if (cmd.kind != ccd_pkg::KIND_FIVE) begin
                give_reg[cmd.kind] <= take_val;
                left_reg           <= left_rem;
            end else if (five_ok) begin
                give_reg[ccd_pkg::KIND_FIVE] <= take_val;
                status_reg                   <= ccd_pkg::ST_OK;
            end else begin
                for (int j = 0; j < ccd_pkg::KINDS; j++) begin
                    give_reg[j] <= '0;
                end
                status_reg <= ccd_pkg::ST_NOCHANGE;
            end
        end
        if (cmd.publish) begin
            m_status_reg <= status_reg;
            for (int j = 0; j < ccd_pkg::KINDS; j++) begin
                m_give_reg[j] <= give_reg[j];
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_give_five    = m_give_reg[0];
    assign m_give_ten     = m_give_reg[1];
    assign m_give_quarter = m_give_reg[2];
    assign m_give_half    = m_give_reg[3];
    assign m_give_unit    = m_give_reg[4];

endmodule

`default_nettype wire
